// ===== hdl/htg_pkg.sv =====
package htg_pkg;

    localparam int DEF_VALUE_WIDTH      = 48;
    localparam int DEF_STEP_COUNT_WIDTH = 16;

    localparam int FRAC_BITS  = 32;   // state fraction bits
    localparam int SHOCK_FRAC = 16;   // shock fraction bits
    localparam int SHOCK_W    = 20;

    localparam int WIDE_W    = 128;   // intermediate magnitudes and signed sums
    localparam int OPB_W     = 64;    // multiplier / divisor operand
    localparam int PROD_W    = WIDE_W + OPB_W;
    localparam int ROOT_W    = 48;
    localparam int CLAMP_BIT = 124;   // intermediates clamp to 2^124-1

    localparam int CNT_W      = 8;
    localparam int MUL_STEPS  = OPB_W;
    localparam int DIV_STEPS  = WIDE_W;
    localparam int SQRT_STEPS = ROOT_W;

    localparam int APB_ADDR_W  = 6;
    localparam int APB_DATA_W  = 64;
    localparam int REG_SEL_LSB = 3;

    localparam logic [WIDE_W-1:0] CLAMP_MAX =
        {{(WIDE_W-CLAMP_BIT){1'b0}}, {CLAMP_BIT{1'b1}}};

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } t_op;

    typedef enum logic [2:0] {
        REG_HALF_KAPPA_DT,
        REG_LONG_RUN_VARIANCE,
        REG_HALF_VOLVOL_SQRT_DT,
        REG_RATE_DT,
        REG_SQRT_DT,
        REG_INITIAL_SPOT,
        REG_INITIAL_VARIANCE,
        REG_STEPS_PER_PATH
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQRT,
        ST_MULK,
        ST_DIV,
        ST_MULV,
        ST_VSEL,
        ST_MULG,
        ST_MULR,
        ST_MULS,
        ST_MULZ,
        ST_MULP,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic              start;
        t_op               op;
        logic [WIDE_W-1:0] a;
        logic [OPB_W-1:0]  b;
    } t_unit_cmd;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [PROD_W-1:0] result;
    } t_unit_sts;

    function automatic logic [WIDE_W-1:0] clamp_mag(input logic [PROD_W-1:0] x);
        return (x[PROD_W-1:CLAMP_BIT] != '0) ? CLAMP_MAX : x[WIDE_W-1:0];
    endfunction

    function automatic logic [WIDE_W-1:0] apply_sign(input logic [WIDE_W-1:0] mag,
                                                     input logic neg);
        return neg ? (~mag + WIDE_W'(1)) : mag;
    endfunction

endpackage

// ===== hdl/htg_if.sv =====
interface htg_item_if;
    logic                              valid;
    logic                              ready;
    logic signed [htg_pkg::SHOCK_W-1:0] shock_spot;
    logic signed [htg_pkg::SHOCK_W-1:0] shock_variance;

    modport source(output valid, shock_spot, shock_variance, input ready);
    modport sink(input valid, shock_spot, shock_variance, output ready);
endinterface

interface htg_result_if #(
    parameter int VALUE_WIDTH = htg_pkg::DEF_VALUE_WIDTH
);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] final_spot;
    logic [VALUE_WIDTH-1:0] final_variance;
    logic                   saturated;

    modport source(output valid, final_spot, final_variance, saturated, input ready);
    modport sink(input valid, final_spot, final_variance, saturated, output ready);
endinterface

// ===== hdl/htg_unit.sv =====
// Shared iterative unit: shift-add multiply (1 bit/cycle), restoring divide
// (1 bit/cycle), digit-by-digit square root (1 root bit/cycle).
module htg_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  htg_pkg::t_unit_cmd i_cmd,
    output htg_pkg::t_unit_sts o_sts
);

    localparam int WW = htg_pkg::WIDE_W;
    localparam int BW = htg_pkg::OPB_W;
    localparam int PW = htg_pkg::PROD_W;

    logic                     r_busy;
    logic                     r_done;
    logic [htg_pkg::CNT_W-1:0] r_cnt;
    htg_pkg::t_op             r_op;
    logic [PW-1:0]            r_acc;
    logic [WW-1:0]            r_a;
    logic [BW-1:0]            r_b;

    logic [PW-1:0]            n_acc;
    logic [WW-1:0]            n_a;
    logic [BW-1:0]            n_b;
    logic [htg_pkg::CNT_W-1:0] w_steps;

    logic [BW:0]              w_rem_d;
    logic [BW:0]              w_diff_d;
    logic                     w_ge_d;
    logic [BW-1:0]            w_rem_s;
    logic [BW-1:0]            w_trial;
    logic                     w_ge_s;

    always_comb begin
        w_rem_d  = {r_acc[PW-1:WW], r_a[WW-1]};
        w_ge_d   = w_rem_d >= {1'b0, r_b};
        w_diff_d = w_rem_d - {1'b0, r_b};
        w_rem_s  = {r_acc[PW-3:WW], r_a[95:94]};
        w_trial  = {r_acc[BW-3:0], 2'b01};
        w_ge_s   = w_rem_s >= w_trial;

        n_acc = r_acc;
        n_a   = r_a;
        n_b   = r_b;
        case (r_op)
            htg_pkg::OP_MUL: begin
                n_acc = (r_acc << 1) + (r_b[BW-1] ? PW'(r_a) : '0);
                n_b   = r_b << 1;
            end
            htg_pkg::OP_DIV: begin
                n_acc = {(w_ge_d ? w_diff_d[BW-1:0] : w_rem_d[BW-1:0]),
                         r_acc[WW-2:0], w_ge_d};
                n_a   = r_a << 1;
            end
            htg_pkg::OP_SQRT: begin
                n_acc = {(w_ge_s ? (w_rem_s - w_trial) : w_rem_s),
                         {(WW-BW){1'b0}}, r_acc[BW-2:0], w_ge_s};
                n_a   = r_a << 2;
            end
            default: begin
                n_acc = r_acc;
            end
        endcase
    end

    always_comb begin
        case (i_cmd.op)
            htg_pkg::OP_MUL:  w_steps = htg_pkg::CNT_W'(htg_pkg::MUL_STEPS);
            htg_pkg::OP_DIV:  w_steps = htg_pkg::CNT_W'(htg_pkg::DIV_STEPS);
            htg_pkg::OP_SQRT: w_steps = htg_pkg::CNT_W'(htg_pkg::SQRT_STEPS);
            default:          w_steps = htg_pkg::CNT_W'(htg_pkg::MUL_STEPS);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= w_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - htg_pkg::CNT_W'(1);
                if (r_cnt == htg_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op  <= i_cmd.op;
            r_a   <= i_cmd.a;
            r_b   <= i_cmd.b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_a   <= n_a;
            r_b   <= n_b;
        end
    end

    assign o_sts.busy   = r_busy;
    assign o_sts.done   = r_done;
    assign o_sts.result = r_acc;

endmodule

// ===== hdl/heston_tg_path_step.sv =====
// One Heston path step per item, computed on a single shared iterative unit
// (multiply, divide and square root, one bit per cycle) driven by a small
// sequencer. An item runs through a square root, a divide and up to seven
// multiplies in turn; the new-variance square is skipped when the
// truncated Gaussian value is negative or too large. The input is ready
// only while idle. After steps_per_path items one result carries final
// spot, variance and a sticky saturation flag; the result sits in an output
// register, so a new item may be taken while it waits. Configuration is an
// APB port with 64-bit data, register i at byte address 8*i; writes to the
// initial spot and variance take effect at the next path start, while other
// writes in mid-path take effect at once.
module heston_tg_path_step #(
    parameter int VALUE_WIDTH      = htg_pkg::DEF_VALUE_WIDTH,
    parameter int STEP_COUNT_WIDTH = htg_pkg::DEF_STEP_COUNT_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [htg_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [htg_pkg::APB_DATA_W-1:0] pwdata,
    output logic [htg_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    htg_item_if.sink                       i_item,
    htg_result_if.source                   o_result
);

    localparam int VW = VALUE_WIDTH;
    localparam int SW = STEP_COUNT_WIDTH;
    localparam int WW = htg_pkg::WIDE_W;
    localparam int BW = htg_pkg::OPB_W;
    localparam int ZW = htg_pkg::SHOCK_W;
    localparam int FB = htg_pkg::FRAC_BITS;

    // configuration
    logic [VW-1:0] r_hk;
    logic [VW-1:0] r_lrv;
    logic [VW-1:0] r_hv;
    logic [VW-1:0] r_rate;
    logic [VW-1:0] r_sqrt_dt;
    logic [VW-1:0] r_init_spot;
    logic [VW-1:0] r_init_var;
    logic [SW-1:0] r_steps;

    // control
    htg_pkg::t_state r_state;
    htg_pkg::t_state n_state;
    logic            r_launched;
    logic [SW-1:0]   r_step;
    logic            r_sat_seen;
    logic            r_out_valid;

    // datapath
    logic [VW-1:0]             r_spot;
    logic [VW-1:0]             r_var;
    logic [ZW-1:0]             r_zs;
    logic                      r_zs_neg;
    logic [ZW-1:0]             r_zv;
    logic                      r_zv_neg;
    logic [htg_pkg::ROOT_W-1:0] r_s;
    logic [WW-1:0]             r_a;
    logic [WW-1:0]             r_g;
    logic [WW-1:0]             r_t;
    logic [VW-1:0]             r_nvar;
    logic                      r_vsat;
    logic [VW-1:0]             r_out_spot;
    logic [VW-1:0]             r_out_var;
    logic                      r_out_sat;

    htg_pkg::t_unit_cmd w_cmd;
    htg_pkg::t_unit_sts w_sts;

    logic              w_cfg_wr;
    logic              w_accept;
    logic [ZW-1:0]     w_zs_raw;
    logic [ZW-1:0]     w_zv_raw;
    logic              w_dneg;
    logic [VW-1:0]     w_mag;
    logic [BW-1:0]     w_div;
    logic              w_rneg;
    logic [VW-1:0]     w_rmag;
    logic [WW-1:0]     w_sq;
    logic              w_spot_low;
    logic              w_spot_high;
    logic [VW-1:0]     w_new_spot;
    logic [SW:0]       w_step_inc;
    logic              w_end;
    logic              w_out_free;
    logic              w_commit;

    htg_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts)
    );

    // ---------------------------------------------------------------- APB
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hk        <= '0;
            r_lrv       <= '0;
            r_hv        <= '0;
            r_rate      <= '0;
            r_sqrt_dt   <= '0;
            r_init_spot <= VW'(64'h1_0000_0000);
            r_init_var  <= '0;
            r_steps     <= SW'(1);
        end else if (w_cfg_wr) begin
            case (htg_pkg::t_reg_idx'(paddr[htg_pkg::APB_ADDR_W-1:htg_pkg::REG_SEL_LSB]))
                htg_pkg::REG_HALF_KAPPA_DT:       r_hk        <= pwdata[VW-1:0];
                htg_pkg::REG_LONG_RUN_VARIANCE:   r_lrv       <= pwdata[VW-1:0];
                htg_pkg::REG_HALF_VOLVOL_SQRT_DT: r_hv        <= pwdata[VW-1:0];
                htg_pkg::REG_RATE_DT:             r_rate      <= pwdata[VW-1:0];
                htg_pkg::REG_SQRT_DT:             r_sqrt_dt   <= pwdata[VW-1:0];
                htg_pkg::REG_INITIAL_SPOT:        r_init_spot <= pwdata[VW-1:0];
                htg_pkg::REG_INITIAL_VARIANCE:    r_init_var  <= pwdata[VW-1:0];
                htg_pkg::REG_STEPS_PER_PATH:      r_steps     <= pwdata[SW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (htg_pkg::t_reg_idx'(paddr[htg_pkg::APB_ADDR_W-1:htg_pkg::REG_SEL_LSB]))
            htg_pkg::REG_HALF_KAPPA_DT:       prdata = htg_pkg::APB_DATA_W'(r_hk);
            htg_pkg::REG_LONG_RUN_VARIANCE:   prdata = htg_pkg::APB_DATA_W'(r_lrv);
            htg_pkg::REG_HALF_VOLVOL_SQRT_DT: prdata = htg_pkg::APB_DATA_W'(r_hv);
            htg_pkg::REG_RATE_DT:             prdata = htg_pkg::APB_DATA_W'(r_rate);
            htg_pkg::REG_SQRT_DT:             prdata = htg_pkg::APB_DATA_W'(r_sqrt_dt);
            htg_pkg::REG_INITIAL_SPOT:        prdata = htg_pkg::APB_DATA_W'(r_init_spot);
            htg_pkg::REG_INITIAL_VARIANCE:    prdata = htg_pkg::APB_DATA_W'(r_init_var);
            htg_pkg::REG_STEPS_PER_PATH:      prdata = htg_pkg::APB_DATA_W'(r_steps);
            default:                          prdata = '0;
        endcase
    end

    // ---------------------------------------------------------- handshake
    assign i_item.ready = (r_state == htg_pkg::ST_IDLE);
    assign w_accept     = i_item.valid && i_item.ready;
    assign w_zs_raw     = i_item.shock_spot;
    assign w_zv_raw     = i_item.shock_variance;

    assign o_result.valid          = r_out_valid;
    assign o_result.final_spot     = r_out_spot;
    assign o_result.final_variance = r_out_var;
    assign o_result.saturated      = r_out_sat;

    // ------------------------------------------------------ operand prep
    // mean-reversion term sign and magnitude, divisor floored at one LSB
    assign w_dneg = r_lrv < r_var;
    assign w_mag  = w_dneg ? (r_var - r_lrv) : (r_lrv - r_var);
    assign w_div  = (r_s == '0) ? BW'(1) : BW'(r_s);
    // rate magnitude: most negative code negates to itself, read unsigned
    assign w_rneg = r_rate[VW-1];
    assign w_rmag = w_rneg ? (~r_rate + VW'(1)) : r_rate;

    // new variance = (g)^2 >> 32, g already known in [0, 2^64)
    assign w_sq = w_sts.result[WW-1:0];

    // spot floor and ceiling
    assign w_spot_low  = r_t[WW-1] || (r_t == '0);
    assign w_spot_high = (r_t[WW-1:VW] != '0);
    assign w_new_spot  = w_spot_low  ? VW'(1) :
                         w_spot_high ? {VW{1'b1}} : r_t[VW-1:0];

    // path end: a shrunk or zero step count ends the path right here
    assign w_step_inc = (SW+1)'(r_step) + (SW+1)'(1);
    assign w_end      = w_step_inc >= (SW+1)'(r_steps);
    assign w_out_free = !r_out_valid || o_result.ready;
    assign w_commit   = (r_state == htg_pkg::ST_FIN) && (!w_end || w_out_free);

    // ------------------------------------------------------- next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            htg_pkg::ST_IDLE: if (w_accept) n_state = htg_pkg::ST_SQRT;
            htg_pkg::ST_SQRT: if (w_sts.done) n_state = htg_pkg::ST_MULK;
            htg_pkg::ST_MULK: if (w_sts.done) n_state = htg_pkg::ST_DIV;
            htg_pkg::ST_DIV:  if (w_sts.done) n_state = htg_pkg::ST_MULV;
            htg_pkg::ST_MULV: if (w_sts.done) n_state = htg_pkg::ST_VSEL;
            htg_pkg::ST_VSEL: begin
                if (!r_g[WW-1] && r_g[WW-1:BW] == '0) begin
                    n_state = htg_pkg::ST_MULG;
                end else begin
                    n_state = htg_pkg::ST_MULR;
                end
            end
            htg_pkg::ST_MULG: if (w_sts.done) n_state = htg_pkg::ST_MULR;
            htg_pkg::ST_MULR: if (w_sts.done) n_state = htg_pkg::ST_MULS;
            htg_pkg::ST_MULS: if (w_sts.done) n_state = htg_pkg::ST_MULZ;
            htg_pkg::ST_MULZ: if (w_sts.done) n_state = htg_pkg::ST_MULP;
            htg_pkg::ST_MULP: if (w_sts.done) n_state = htg_pkg::ST_FIN;
            htg_pkg::ST_FIN:  if (w_commit) n_state = htg_pkg::ST_IDLE;
            default:          n_state = htg_pkg::ST_IDLE;
        endcase
    end

    // ---------------------------------------------------- unit commands
    always_comb begin
        w_cmd       = '0;
        w_cmd.op    = htg_pkg::OP_MUL;
        case (r_state)
            htg_pkg::ST_SQRT: begin
                w_cmd.op = htg_pkg::OP_SQRT;
                w_cmd.a  = WW'(r_var) << FB;
            end
            htg_pkg::ST_MULK: begin
                w_cmd.a = WW'(r_hk);
                w_cmd.b = BW'(w_mag);
            end
            htg_pkg::ST_DIV: begin
                w_cmd.op = htg_pkg::OP_DIV;
                w_cmd.a  = r_a;
                w_cmd.b  = w_div;
            end
            htg_pkg::ST_MULV: begin
                w_cmd.a = WW'(r_hv);
                w_cmd.b = BW'(r_zv);
            end
            htg_pkg::ST_MULG: begin
                w_cmd.a = WW'(r_g[BW-1:0]);
                w_cmd.b = r_g[BW-1:0];
            end
            htg_pkg::ST_MULR: begin
                w_cmd.a = WW'(r_spot);
                w_cmd.b = BW'(w_rmag);
            end
            htg_pkg::ST_MULS: begin
                w_cmd.a = WW'(r_s);
                w_cmd.b = BW'(r_sqrt_dt);
            end
            htg_pkg::ST_MULZ: begin
                w_cmd.a = r_a;
                w_cmd.b = BW'(r_zs);
            end
            htg_pkg::ST_MULP: begin
                w_cmd.a = r_a;
                w_cmd.b = BW'(r_spot);
            end
            default: begin
            end
        endcase
        w_cmd.start = !r_launched
                      && (r_state != htg_pkg::ST_IDLE)
                      && (r_state != htg_pkg::ST_VSEL)
                      && (r_state != htg_pkg::ST_FIN);
    end

    // ------------------------------------------------------ control regs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= htg_pkg::ST_IDLE;
            r_launched  <= 1'b0;
            r_step      <= '0;
            r_sat_seen  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cmd.start) begin
                r_launched <= 1'b1;
            end else if (w_sts.done) begin
                r_launched <= 1'b0;
            end
            if (w_accept && r_step == '0) begin
                r_sat_seen <= 1'b0;
            end
            if (r_out_valid && o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_commit) begin
                if (w_end) begin
                    r_step      <= '0;
                    r_sat_seen  <= 1'b0;
                    r_out_valid <= 1'b1;
                end else begin
                    r_step     <= w_step_inc[SW-1:0];
                    r_sat_seen <= r_sat_seen || r_vsat || (!w_spot_low && w_spot_high);
                end
            end
        end
    end

    // ----------------------------------------------------- datapath regs
    always_ff @(posedge i_clk) begin
        case (r_state)
            htg_pkg::ST_IDLE: begin
                if (w_accept) begin
                    r_zs_neg <= w_zs_raw[ZW-1];
                    r_zs     <= w_zs_raw[ZW-1] ? (~w_zs_raw + ZW'(1)) : w_zs_raw;
                    r_zv_neg <= w_zv_raw[ZW-1];
                    r_zv     <= w_zv_raw[ZW-1] ? (~w_zv_raw + ZW'(1)) : w_zv_raw;
                    r_vsat   <= 1'b0;
                    if (r_step == '0) begin
                        r_spot <= r_init_spot;
                        r_var  <= r_init_var;
                    end
                end
            end
            htg_pkg::ST_SQRT: begin
                if (w_sts.done) r_s <= w_sts.result[htg_pkg::ROOT_W-1:0];
            end
            htg_pkg::ST_MULK: begin
                if (w_sts.done) r_a <= w_sts.result[WW-1:0];
            end
            htg_pkg::ST_DIV: begin
                if (w_sts.done) begin
                    r_g <= WW'(r_s) + htg_pkg::apply_sign(
                        htg_pkg::clamp_mag(htg_pkg::PROD_W'(w_sts.result[WW-1:0])), w_dneg);
                end
            end
            htg_pkg::ST_MULV: begin
                if (w_sts.done) begin
                    r_g <= r_g + htg_pkg::apply_sign(
                        htg_pkg::clamp_mag(w_sts.result >> htg_pkg::SHOCK_FRAC), r_zv_neg);
                end
            end
            htg_pkg::ST_VSEL: begin
                // negative g truncates to zero; g of 2^64 or more cannot square in range
                if (r_g[WW-1]) begin
                    r_nvar <= '0;
                end else if (r_g[WW-1:BW] != '0) begin
                    r_nvar <= {VW{1'b1}};
                    r_vsat <= 1'b1;
                end
            end
            htg_pkg::ST_MULG: begin
                if (w_sts.done) begin
                    if (w_sq[WW-1:FB+VW] != '0) begin
                        r_nvar <= {VW{1'b1}};
                        r_vsat <= 1'b1;
                    end else begin
                        r_nvar <= w_sq[FB+VW-1:FB];
                    end
                end
            end
            htg_pkg::ST_MULR: begin
                if (w_sts.done) begin
                    r_t <= WW'(r_spot) + htg_pkg::apply_sign(
                        htg_pkg::clamp_mag(w_sts.result >> FB), w_rneg);
                end
            end
            htg_pkg::ST_MULS: begin
                if (w_sts.done) r_a <= htg_pkg::clamp_mag(w_sts.result >> FB);
            end
            htg_pkg::ST_MULZ: begin
                if (w_sts.done) r_a <= htg_pkg::clamp_mag(w_sts.result >> htg_pkg::SHOCK_FRAC);
            end
            htg_pkg::ST_MULP: begin
                if (w_sts.done) begin
                    r_t <= r_t + htg_pkg::apply_sign(
                        htg_pkg::clamp_mag(w_sts.result >> FB), r_zs_neg);
                end
            end
            htg_pkg::ST_FIN: begin
                if (w_commit) begin
                    r_spot <= w_new_spot;
                    r_var  <= r_nvar;
                    if (w_end) begin
                        r_out_spot <= w_new_spot;
                        r_out_var  <= r_nvar;
                        r_out_sat  <= r_sat_seen || r_vsat || (!w_spot_low && w_spot_high);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------- checks
    a_start_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.start |-> !w_sts.busy)
        else $error("unit started while busy");

    a_idle_unit_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == htg_pkg::ST_IDLE) |-> (!w_sts.busy && !r_launched))
        else $error("unit active while idle");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == htg_pkg::ST_FIN))
        else $error("result raised outside final step");

    a_spot_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_spot != '0))
        else $error("final spot is zero");

endmodule

// ===== tb/sv/htg_path_checker.sv =====
`timescale 1ns / 100ps

// Watches the item, result and APB channels, keeps its own copy of the
// path state and registers, and checks each result against the oldest prediction.
module htg_path_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic                           pready,
    input  logic [htg_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [htg_pkg::APB_DATA_W-1:0] pwdata,
    htg_item_if                            item,
    htg_result_if                          result,
    output int                             o_mismatches,
    output int                             o_pending
);

    localparam logic [47:0] VMAX = {48{1'b1}};

    typedef struct packed {
        logic [47:0] spot;
        logic [47:0] variance;
        logic        sat;
    } t_path_end;

    logic [47:0] kappa_h, theta, volvol_h, rate, sqdt, spot0, var0;
    logic [15:0] nsteps;
    logic [47:0] spot_q, var_q;
    logic [15:0] step_q;
    logic        sat_q;
    t_path_end   path_ends[$];
    int          mismatches;

    assign o_mismatches = mismatches;
    assign o_pending    = path_ends.size();

    function automatic logic [127:0] clip124(logic [255:0] x);
        return ((x >> htg_pkg::CLAMP_BIT) != 0) ? htg_pkg::CLAMP_MAX : x[127:0];
    endfunction

    // (a*b) >> sh, magnitude truncated then clamped
    function automatic logic [127:0] mul_shift(logic [127:0] a, logic [63:0] b, int sh);
        logic [255:0] p;
        p = {128'd0, a} * {192'd0, b};
        return clip124(p >> sh);
    endfunction

    function automatic logic [47:0] root_q(logic [47:0] v);
        logic [127:0] n;
        logic [47:0]  r, c;
        n = {48'd0, v, 32'd0};
        r = '0;
        for (int b = 47; b >= 0; b--) begin
            c = r | (48'd1 << b);
            if ({80'd0, c} * {80'd0, c} <= n) r = c;
        end
        return r;
    endfunction

    function automatic logic signed [127:0] signed_mag(logic [127:0] m, logic neg);
        return neg ? -$signed(m) : $signed(m);
    endfunction

    // One time step; returns 1 when the path ends and fills pe.
    function automatic bit advance_path(logic [19:0] zs_raw, logic [19:0] zv_raw,
                                        output t_path_end pe);
        logic [47:0]  s, d, dmag, nv, ns, rmag;
        logic [63:0]  zs, zv;
        logic         zsn, zvn, dneg, rneg, sat;
        logic signed [127:0] g, t;
        logic [127:0] sq, a;
        int           zi;
        sat = 1'b0;
        if (step_q == 0) begin
            spot_q = spot0;
            var_q  = var0;
            sat_q  = 1'b0;
        end
        zi  = $signed(zs_raw);
        zsn = zi < 0;
        zs  = zsn ? 64'(-zi) : 64'(zi);
        zi  = $signed(zv_raw);
        zvn = zi < 0;
        zv  = zvn ? 64'(-zi) : 64'(zi);

        s    = root_q(var_q);
        d    = (s != 0) ? s : 48'd1;
        dneg = theta < var_q;
        dmag = dneg ? var_q - theta : theta - var_q;
        g = $signed({80'd0, s})
            + signed_mag(clip124({160'd0, {48'd0, kappa_h} * {48'd0, dmag}} / {208'd0, d}),
                         dneg)
            + signed_mag(mul_shift({80'd0, volvol_h}, zv, htg_pkg::SHOCK_FRAC), zvn);
        if (g[127]) begin
            nv = '0;
        end else if (g[127:64] != 0) begin
            nv = VMAX; sat = 1'b1;
        end else begin
            sq = {64'd0, g[63:0]} * {64'd0, g[63:0]};
            if ((sq >> htg_pkg::FRAC_BITS) > {80'd0, VMAX}) begin
                nv = VMAX; sat = 1'b1;
            end else begin
                nv = sq[79:32];
            end
        end

        rneg = rate[47];
        rmag = rneg ? (~rate + 48'd1) : rate;
        a = mul_shift({80'd0, s}, {16'd0, sqdt}, htg_pkg::FRAC_BITS);
        a = mul_shift(a, zs, htg_pkg::SHOCK_FRAC);
        a = mul_shift(a, {16'd0, spot_q}, htg_pkg::FRAC_BITS);
        t = $signed({80'd0, spot_q})
            + signed_mag(mul_shift({80'd0, spot_q}, {16'd0, rmag}, htg_pkg::FRAC_BITS), rneg)
            + signed_mag(a, zsn);
        if (t[127] || t == 0) begin
            ns = 48'd1;
        end else if (t > $signed({80'd0, VMAX})) begin
            ns = VMAX; sat = 1'b1;
        end else begin
            ns = t[47:0];
        end

        spot_q = ns;
        var_q  = nv;
        sat_q  = sat_q | sat;
        if ({16'd0, step_q} + 32'd1 >= {16'd0, nsteps}) begin
            pe.spot     = ns;
            pe.variance = nv;
            pe.sat      = sat_q;
            step_q = '0;
            spot_q = spot0;
            var_q  = var0;
            sat_q  = 1'b0;
            return 1'b1;
        end
        step_q = step_q + 16'd1;
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin
        t_path_end pe, got;
        if (!i_rst_n) begin
            kappa_h  <= '0; theta <= '0; volvol_h <= '0; rate <= '0; sqdt <= '0;
            spot0    <= 48'd1 << htg_pkg::FRAC_BITS;
            var0     <= '0;
            nsteps   <= 16'd1;
            spot_q   = 48'd1 << htg_pkg::FRAC_BITS;
            var_q    = '0;
            step_q   = '0;
            sat_q    = 1'b0;
            mismatches <= 0;
            path_ends.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (htg_pkg::t_reg_idx'(paddr[htg_pkg::APB_ADDR_W-1:htg_pkg::REG_SEL_LSB]))
                    htg_pkg::REG_HALF_KAPPA_DT:       kappa_h  <= pwdata[47:0];
                    htg_pkg::REG_LONG_RUN_VARIANCE:   theta    <= pwdata[47:0];
                    htg_pkg::REG_HALF_VOLVOL_SQRT_DT: volvol_h <= pwdata[47:0];
                    htg_pkg::REG_RATE_DT:             rate     <= pwdata[47:0];
                    htg_pkg::REG_SQRT_DT:             sqdt     <= pwdata[47:0];
                    htg_pkg::REG_INITIAL_SPOT:        spot0    <= pwdata[47:0];
                    htg_pkg::REG_INITIAL_VARIANCE:    var0     <= pwdata[47:0];
                    htg_pkg::REG_STEPS_PER_PATH:      nsteps   <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (item.valid && item.ready) begin
                if (advance_path(item.shock_spot, item.shock_variance, pe))
                    path_ends.push_back(pe);
            end
            if (result.valid && result.ready) begin
                got = '{result.final_spot, result.final_variance, result.saturated};
                if (path_ends.size() == 0) begin
                    if (mismatches < 10) $display("unexpected result %p", got);
                    mismatches <= mismatches + 1;
                end else begin
                    pe = path_ends.pop_front();
                    if (got !== pe) begin
                        if (mismatches < 10)
                            $display({"result mismatch: exp spot=%h var=%h sat=%b",
                                      " got spot=%h var=%h sat=%b"},
                                     pe.spot, pe.variance, pe.sat,
                                     got.spot, got.variance, got.sat);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    // covers the slowest correct run, gaps and stalls included, many times over
    localparam int CYCLE_LIMIT = 6_000_000;
    localparam int BLOCK_LAT   = 800;      // one full item through the sequencer, with margin
    localparam logic [63:0] ONE = 64'd1 << htg_pkg::FRAC_BITS;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           psel, penable, pwrite;
    logic [htg_pkg::APB_ADDR_W-1:0] paddr;
    logic [htg_pkg::APB_DATA_W-1:0] pwdata;
    logic [htg_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;
    int                             mismatches, pending;
    int                             cycles = 0;
    bit                             quiet;      // no idling in the closing part
    bit                             hold_req;   // ask the receiver for one long stall

    htg_item_if   item_ch ();
    htg_result_if result_ch ();

    heston_tg_path_step DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_item  (item_ch.sink),
        .o_result(result_ch.source)
    );

    htg_path_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .item        (item_ch),
        .result      (result_ch),
        .o_mismatches(mismatches),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: random ready bursts, one long hold-off on request, none at the end.
    initial begin
        int n;
        result_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                result_ch.ready <= 1'b0;
                n = 0;
                while (n < 5000) begin
                    @(posedge i_clk);
                    n++;
                end
                hold_req = 1'b0;
            end else if (quiet || $urandom_range(0, 3) == 0) begin
                result_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 200)) @(posedge i_clk);
            end else begin
                result_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end
        end
    end

    task automatic reg_write(htg_pkg::t_reg_idx idx, logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= htg_pkg::APB_ADDR_W'(idx) << htg_pkg::REG_SEL_LSB;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // drop valid after the last item of a batch
    task automatic stop_items();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Only while idle: all results in, then one item's worth of cycles
    // in case a step that ends no path is still running.
    task automatic load_model(logic [63:0] kh, logic [63:0] th, logic [63:0] vh,
                              logic [63:0] r, logic [63:0] sd, logic [63:0] s0,
                              logic [63:0] v0, logic [63:0] ns);
        stop_items();
        wait (pending == 0);
        repeat (BLOCK_LAT) @(posedge i_clk);
        reg_write(htg_pkg::REG_HALF_KAPPA_DT, kh);
        reg_write(htg_pkg::REG_LONG_RUN_VARIANCE, th);
        reg_write(htg_pkg::REG_HALF_VOLVOL_SQRT_DT, vh);
        reg_write(htg_pkg::REG_RATE_DT, r);
        reg_write(htg_pkg::REG_SQRT_DT, sd);
        reg_write(htg_pkg::REG_INITIAL_SPOT, s0);
        reg_write(htg_pkg::REG_INITIAL_VARIANCE, v0);
        reg_write(htg_pkg::REG_STEPS_PER_PATH, ns);
    endtask

    // valid stays high between back-to-back items
    task automatic send_shocks(logic [19:0] zs, logic [19:0] zv);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        item_ch.valid          <= 1'b1;
        item_ch.shock_spot     <= zs;
        item_ch.shock_variance <= zv;
        do @(posedge i_clk); while (!item_ch.ready);
    endtask

    // Mostly bell-shaped shocks of a few sigma, some full-range codes.
    function automatic logic [19:0] rand_shock();
        int acc;
        if ($urandom_range(0, 4) == 0) return 20'($urandom);
        acc = 0;
        for (int k = 0; k < 4; k++) acc += $urandom_range(0, 65536) - 32768;
        return 20'(acc);
    endfunction

    function automatic logic [63:0] rand48(int bits);
        return {$urandom, $urandom} & ((64'd1 << bits) - 64'd1);
    endfunction

    task automatic random_items(int count);
        for (int k = 0; k < count; k++) send_shocks(rand_shock(), rand_shock());
    endtask

    localparam logic [19:0] ZMAX = 20'h7FFFF;
    localparam logic [19:0] ZMIN = 20'h80000;

    initial begin
        logic [63:0] s0;
        i_rst_n = 1'b0;
        quiet   = 1'b0;
        hold_req = 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        item_ch.valid          <= 1'b0;
        item_ch.shock_spot     <= '0;
        item_ch.shock_variance <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values: zero variance divides by one LSB
        send_shocks(ZMAX, ZMIN);
        send_shocks(20'd0, 20'd0);

        // nominal market: kappa 2, theta 0.04, xi 0.5, r 5%, dt 1/256, spot 100
        load_model(64'd1 << 24, 64'd171798692, 64'd1 << 26, 64'd838861, 64'd1 << 28,
                   100 * ONE, 64'd171798692, 64'd1);
        send_shocks(ZMAX, ZMAX);
        send_shocks(ZMIN, ZMIN);
        send_shocks(ZMAX, ZMIN);
        send_shocks(ZMIN, ZMAX);
        send_shocks(20'd0, 20'd1);

        // registers at their top codes (rate most positive, two steps): saturation of spot and variance
        load_model({48{1'b1}}, {48{1'b1}}, {48{1'b1}}, 64'h7FFF_FFFF_FFFF, {48{1'b1}},
                   {48{1'b1}}, {48{1'b1}}, 64'd2);
        send_shocks(ZMAX, ZMAX);
        send_shocks(ZMIN, ZMIN);
        send_shocks(ZMAX, ZMIN);
        send_shocks(ZMIN, ZMAX);

        // everything zero, one LSB spot, step count zero acting as one;
        // most negative rate drives spot to the floor
        load_model(64'd0, 64'd0, 64'd0, 64'h8000_0000_0000, 64'd0, 64'd1, 64'd0, 64'd0);
        send_shocks(ZMIN, ZMIN);
        send_shocks(ZMAX, ZMAX);

        // huge shock on spot makes it non-positive: floor, not saturation
        load_model(64'd0, ONE, 64'd0, 64'd0, 4 * ONE, ONE, ONE, 64'd1);
        send_shocks(ZMIN, 20'd0);
        send_shocks(ZMAX, ZMIN);

        // longest path, then shrunk under a running path
        load_model(64'd1 << 24, 64'd171798692, 64'd1 << 26, 64'd838861, 64'd1 << 28,
                   100 * ONE, 64'd171798692, 64'd65535);
        random_items(4);
        load_model(64'd1 << 24, 64'd171798692, 64'd1 << 26, 64'd838861, 64'd1 << 28,
                   100 * ONE, 64'd171798692, 64'd3);
        send_shocks(rand_shock(), rand_shock());

        // one-step paths with a long receiver hold-off: block fills and stalls
        load_model(64'd1 << 24, 64'd171798692, 64'd1 << 26, 64'd838861, 64'd1 << 28,
                   100 * ONE, 64'd171798692, 64'd1);
        hold_req = 1'b1;
        random_items(200);

        // random realistic parameters, short paths
        for (int ph = 0; ph < 6; ph++) begin
            s0 = rand48(40) | 64'd1;
            load_model(rand48(28), rand48(32), rand48(28),
                       {{16{1'b0}}, {48{1'($urandom_range(0, 1))}}} ^ rand48(22),
                       rand48(30), s0, rand48(32), 64'($urandom_range(1, 8)));
            random_items(100);
            // sender waits until all expected results are in
            stop_items();
            wait (pending == 0);
            random_items(100);
        end

        // full-width random registers
        load_model(rand48(48), rand48(48), rand48(48), rand48(48), rand48(48),
                   rand48(48) | 64'd1, rand48(48), 64'($urandom_range(1, 4)));
        random_items(150);

        // closing part: no idling on either side
        load_model(64'd1 << 24, 64'd171798692, 64'd1 << 26, 64'd838861, 64'd1 << 28,
                   100 * ONE, 64'd171798692, 64'd2);
        quiet = 1'b1;
        random_items(200);

        stop_items();
        wait (pending == 0);
        repeat (BLOCK_LAT) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
